// File: hw/rtl/lik_pkg.sv
// Shared types, widths, constants and helper functions for the leg inverse
// kinematics block. Used by the channel interfaces, the CORDIC unit and the top level.
// No dependencies.
package lik_pkg;

    // Fixed-point format and default iteration count.
    localparam int FRAC_BITS        = 16;
    localparam int ANGLE_ITERATIONS = 16;
    localparam int ATAN_TABLE_LEN   = 24;

    // Field widths.
    localparam int COORD_W   = 20;
    localparam int LEN_W     = 18;
    localparam int ANGLE_W   = 19;
    localparam int LEG_W     = 2;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LINK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LINK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_LEN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WID   = 2'd3;

    // Configuration reset values.
    localparam logic [LEN_W-1:0] UPPER_LINK_RST = 18'd13107;
    localparam logic [LEN_W-1:0] LOWER_LINK_RST = 18'd13107;
    localparam logic [LEN_W-1:0] HALF_LEN_RST   = 18'd16384;
    localparam logic [LEN_W-1:0] HALF_WID_RST   = 18'd9830;

    // Leg codes.
    localparam logic [LEG_W-1:0] LEG_FRONT_LEFT  = 2'd0;
    localparam logic [LEG_W-1:0] LEG_FRONT_RIGHT = 2'd1;
    localparam logic [LEG_W-1:0] LEG_BACK_RIGHT  = 2'd2;
    localparam logic [LEG_W-1:0] LEG_BACK_LEFT   = 2'd3;

    // CORDIC angle accumulator in Q30 radians.
    localparam int    ZACC_W    = 34;
    localparam longint PI_Q30    = 64'sd3373259426;
    localparam longint ROUND_Q30 = 64'sd1 <<< (29 - FRAC_BITS);
    localparam longint PI_FIXED  = (PI_Q30 + ROUND_Q30) >>> (30 - FRAC_BITS);

    // atan(2^-i) in Q30.
    function automatic logic signed [ZACC_W-1:0] atan_q30(input int i);
        logic signed [ZACC_W-1:0] v;
        case (i)
            0:  v = 34'sd843314857;
            1:  v = 34'sd497837829;
            2:  v = 34'sd263043836;
            3:  v = 34'sd133525159;
            4:  v = 34'sd67021687;
            5:  v = 34'sd33543516;
            6:  v = 34'sd16775851;
            7:  v = 34'sd8388437;
            8:  v = 34'sd4194283;
            9:  v = 34'sd2097149;
            10: v = 34'sd1048576;
            11: v = 34'sd524288;
            12: v = 34'sd262144;
            13: v = 34'sd131072;
            14: v = 34'sd65536;
            15: v = 34'sd32768;
            16: v = 34'sd16384;
            17: v = 34'sd8192;
            18: v = 34'sd4096;
            19: v = 34'sd2048;
            20: v = 34'sd1024;
            21: v = 34'sd512;
            22: v = 34'sd256;
            23: v = 34'sd128;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Digit-by-digit square root state, wide enough for both roots.
    localparam int SQRT_REM_W  = 44;
    localparam int SQRT_ROOT_W = 22;

    typedef struct packed {
        logic [SQRT_REM_W-1:0]  rem;
        logic [SQRT_ROOT_W-1:0] root;
    } t_sqrt_st;

    // One root bit: try setting bit b and keep it if the square still fits.
    function automatic t_sqrt_st sqrt_step(input t_sqrt_st s, input int b);
        logic [SQRT_REM_W-1:0] test;
        t_sqrt_st              n;
        test = (SQRT_REM_W'(s.root) << (b + 1)) + (SQRT_REM_W'(1) << (2 * b));
        n = s;
        if (s.rem >= test) begin
            n.rem  = s.rem - test;
            n.root = s.root | (SQRT_ROOT_W'(1) << b);
        end
        return n;
    endfunction

    // Knee cosine classification carried beside the divider.
    typedef struct packed {
        logic sat_hi;
        logic sat_lo;
        logic neg;
    } t_cls;

endpackage

// File: hw/rtl/lik_target_if.sv
// Input channel: one foot target and leg select per transaction.
// Depends on lik_pkg for field widths.
interface lik_target_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [lik_pkg::COORD_W-1:0]    target_x;
    logic signed [lik_pkg::COORD_W-1:0]    target_y;
    logic signed [lik_pkg::COORD_W-1:0]    target_z;
    logic        [lik_pkg::LEG_W-1:0]      leg_select;

    modport source (output valid, output target_x, output target_y, output target_z,
                    output leg_select, input ready);
    modport sink   (input valid, input target_x, input target_y, input target_z,
                    input leg_select, output ready);
endinterface

// File: hw/rtl/lik_joint_if.sv
// Output channel: three joint angles and the reach flag per transaction.
// Depends on lik_pkg for field widths.
interface lik_joint_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [lik_pkg::ANGLE_W-1:0]    abduction_angle;
    logic signed [lik_pkg::ANGLE_W-1:0]    hip_angle;
    logic signed [lik_pkg::ANGLE_W-1:0]    knee_angle;
    logic                                  reachable;

    modport source (output valid, output abduction_angle, output hip_angle,
                    output knee_angle, output reachable, input ready);
    modport sink   (input valid, input abduction_angle, input hip_angle,
                    input knee_angle, input reachable, output ready);
endinterface

// File: hw/rtl/lik_cordic.sv
// Pipelined vectoring CORDIC atan2 with one rotation per stage.
// Fold, rotation and output registers advance on i_en. Depends on lik_pkg.
module lik_cordic #(
    parameter int DATA_W     = 21,
    parameter int ITERATIONS = lik_pkg::ANGLE_ITERATIONS
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [DATA_W-1:0]           i_y,
    input  logic signed [DATA_W-1:0]           i_x,
    output logic signed [lik_pkg::ANGLE_W-1:0] o_angle
);
    localparam int W  = DATA_W + 2;
    localparam int ZW = lik_pkg::ZACC_W;
    localparam int SH = 30 - lik_pkg::FRAC_BITS;

    localparam logic signed [ZW-1:0] PI_Z  = ZW'(lik_pkg::PI_Q30);
    localparam logic signed [ZW-1:0] RND_Z = ZW'(lik_pkg::ROUND_Q30);
    localparam logic signed [ZW-1:0] PI_F  = ZW'(lik_pkg::PI_FIXED);

    logic signed [W-1:0]  r_x    [0:ITERATIONS];
    logic signed [W-1:0]  r_y    [0:ITERATIONS];
    logic signed [ZW-1:0] r_z    [0:ITERATIONS];
    logic                 r_zero [0:ITERATIONS];
    logic signed [lik_pkg::ANGLE_W-1:0] r_angle;

    logic signed [W-1:0]  xe;
    logic signed [W-1:0]  ye;
    logic signed [ZW-1:0] rnd;
    logic signed [ZW-1:0] shv;
    logic signed [ZW-1:0] clamped;

    assign xe = W'(i_x);
    assign ye = W'(i_y);

    // Fold the left half plane onto the right half plane.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            if (i_x < 0) begin
                r_x[0] <= -xe;
                r_y[0] <= -ye;
                r_z[0] <= (i_y >= 0) ? PI_Z : -PI_Z;
            end else begin
                r_x[0] <= xe;
                r_y[0] <= ye;
                r_z[0] <= '0;
            end
        end
    end

    // One micro-rotation per stage, driving y toward zero.
    for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
        logic signed [W-1:0] xs;
        logic signed [W-1:0] ys;
        assign xs = r_x[i] >>> i;
        assign ys = r_y[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[i+1] <= r_zero[i];
                if (r_y[i] > 0) begin
                    r_x[i+1] <= r_x[i] + ys;
                    r_y[i+1] <= r_y[i] - xs;
                    r_z[i+1] <= r_z[i] + lik_pkg::atan_q30(i);
                end else begin
                    r_x[i+1] <= r_x[i] - ys;
                    r_y[i+1] <= r_y[i] + xs;
                    r_z[i+1] <= r_z[i] - lik_pkg::atan_q30(i);
                end
            end
        end
    end

    // Round half up to the output format and clamp to plus or minus pi.
    assign rnd = r_z[ITERATIONS] + RND_Z;
    assign shv = rnd >>> SH;
    always_comb begin
        if (shv > PI_F) begin
            clamped = PI_F;
        end else if (shv < -PI_F) begin
            clamped = -PI_F;
        end else begin
            clamped = shv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle <= r_zero[ITERATIONS] ? '0 : clamped[lik_pkg::ANGLE_W-1:0];
        end
    end

    assign o_angle = r_angle;

endmodule

// File: hw/rtl/leg_inverse_kinematics.sv
// Three-joint leg inverse kinematics. A foot target enters as one transaction per
// cycle unless the pipeline holds, and its joint angles leave in order. The longest
// path runs through a 17-stage restoring divider for the knee cosine, a 17-stage
// square root for the knee sine and the hip CORDIC of ANGLE_ITERATIONS + 2 stages.
// All stages advance together; the pipeline holds whenever the output register is
// full and not being taken.
// Depends on lik_pkg, lik_target_if, lik_joint_if and lik_cordic.
module leg_inverse_kinematics #(
    parameter int ANGLE_ITERATIONS = lik_pkg::ANGLE_ITERATIONS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [lik_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lik_pkg::LEN_W-1:0]          i_cfg_data,
    lik_target_if.sink                         i_target,
    lik_joint_if.source                        o_joint
);
    localparam int F        = lik_pkg::FRAC_BITS;
    localparam int LEN_W    = lik_pkg::LEN_W;
    localparam int POS_W    = lik_pkg::COORD_W + 1;
    localparam int SQ_W     = 2 * POS_W - 1;
    localparam int RSQ_W    = SQ_W + 1;
    localparam int PL_W     = 2 * LEN_W;
    localparam int DEN_W    = PL_W + 1;
    localparam int REM_W    = DEN_W + 1;
    localparam int NUM_W    = 44;
    localparam int Q_W      = F + 1;
    localparam int C2_W     = F + 2;
    localparam int C2SQ_W   = 2 * F + 1;
    localparam int A2C2_W   = LEN_W + 1 + C2_W;
    localparam int K_W      = LEN_W + 3;
    localparam int SMAG_W   = F + 1;
    localparam int M_W      = LEN_W + SMAG_W;
    localparam int T_W      = M_W + 1 - F;
    localparam int RHO_W    = RSQ_W / 2;
    localparam int PROD_W   = 44;
    localparam int C_LAT    = ANGLE_ITERATIONS + 2;

    localparam int DIV_STEPS = F + 1;
    localparam int S_STEPS   = F + 1;
    localparam int RHO_STEPS = RHO_W;

    // Pipeline timeline: register stage at which each value becomes available.
    localparam int T_IN   = 1;
    localparam int T_SQ   = T_IN + 1;
    localparam int T_SUM  = T_SQ + 1;
    localparam int T_NUM  = T_SUM + 1;
    localparam int T_CLS  = T_NUM + 1;
    localparam int T_DIV  = T_CLS + DIV_STEPS;
    localparam int T_C2   = T_DIV + 1;
    localparam int T_C2M  = T_C2 + 1;
    localparam int T_K    = T_C2M + 1;
    localparam int T_SMAG = T_K + S_STEPS;
    localparam int T_S2   = T_SMAG + 1;
    localparam int T_T    = T_S2 + 1;
    localparam int T_P    = T_T + 1;
    localparam int T_SC   = T_P + 1;
    localparam int T_RHO  = T_SUM + RHO_STEPS;
    localparam int T_LAST = T_SC + C_LAT;

    localparam int PZ_DLY    = T_T - T_IN;
    localparam int K_DLY     = T_T - T_K;
    localparam int RHO_DLY   = T_T - T_RHO;
    localparam int C2_DLY    = T_S2 - T_C2;
    localparam int KNEE_DLY  = T_SC - T_S2;
    localparam int ABD_DLY   = T_SC - T_IN;
    localparam int REACH_DLY = T_LAST - T_C2;

    localparam logic signed [C2_W-1:0] ONE = C2_W'(1) << F;

    // Configuration registers.
    logic [LEN_W-1:0] r_upper_link;
    logic [LEN_W-1:0] r_lower_link;
    logic [LEN_W-1:0] r_half_len;
    logic [LEN_W-1:0] r_half_wid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper_link <= lik_pkg::UPPER_LINK_RST;
            r_lower_link <= lik_pkg::LOWER_LINK_RST;
            r_half_len   <= lik_pkg::HALF_LEN_RST;
            r_half_wid   <= lik_pkg::HALF_WID_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lik_pkg::CFG_UPPER_LINK: r_upper_link <= i_cfg_data;
                lik_pkg::CFG_LOWER_LINK: r_lower_link <= i_cfg_data;
                lik_pkg::CFG_HALF_LEN:   r_half_len   <= i_cfg_data;
                lik_pkg::CFG_HALF_WID:   r_half_wid   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Link-derived terms; users must keep configuration static with items in flight.
    logic [PL_W-1:0]  r_a1a2;
    logic [PL_W-1:0]  r_a1sq;
    logic [PL_W-1:0]  r_a2sq;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_asum;
    logic             r_den_zero;

    always_ff @(posedge i_clk) begin
        r_a1a2     <= r_upper_link * r_lower_link;
        r_a1sq     <= r_upper_link * r_upper_link;
        r_a2sq     <= r_lower_link * r_lower_link;
        r_den      <= {r_a1a2, 1'b0};
        r_asum     <= {1'b0, r_a1sq} + {1'b0, r_a2sq};
        r_den_zero <= (r_a1a2 == '0);
    end

    // Global stage enable and valid bits.
    logic en;
    logic r_vld [1:T_LAST];

    assign en             = !r_vld[T_LAST] || o_joint.ready;
    assign i_target.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= T_LAST; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[1] <= i_target.valid;
            for (int k = 2; k <= T_LAST; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Stage 1: remove the hip offset and swap into the leg frame.
    logic signed [POS_W-1:0] tx_e, ty_e, tz_e, hl_e, hw_e;
    logic signed [POS_W-1:0] r_px, r_py, r_pz;
    logic                    front_leg, left_leg;

    assign tx_e = POS_W'(i_target.target_x);
    assign ty_e = POS_W'(i_target.target_y);
    assign tz_e = POS_W'(i_target.target_z);
    assign hl_e = $signed({{(POS_W-LEN_W){1'b0}}, r_half_len});
    assign hw_e = $signed({{(POS_W-LEN_W){1'b0}}, r_half_wid});
    assign front_leg = (i_target.leg_select == lik_pkg::LEG_FRONT_LEFT)
                    || (i_target.leg_select == lik_pkg::LEG_FRONT_RIGHT);
    assign left_leg  = (i_target.leg_select == lik_pkg::LEG_FRONT_LEFT)
                    || (i_target.leg_select == lik_pkg::LEG_BACK_LEFT);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pz <= front_leg ? tx_e - hl_e : tx_e + hl_e;
            r_py <= left_leg ? ty_e - hw_e : ty_e + hw_e;
            r_px <= -tz_e;
        end
    end

    // Stage 2: coordinate squares.
    logic signed [2*POS_W-1:0] n_px2, n_py2, n_pz2;
    logic [SQ_W-1:0]           r_px2, r_py2, r_pz2;

    assign n_px2 = r_px * r_px;
    assign n_py2 = r_py * r_py;
    assign n_pz2 = r_pz * r_pz;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px2 <= n_px2[SQ_W-1:0];
            r_py2 <= n_py2[SQ_W-1:0];
            r_pz2 <= n_pz2[SQ_W-1:0];
        end
    end

    // Stage 3: horizontal radius squared; it also seeds the radius square root.
    logic [RSQ_W-1:0] r_rho_sq;
    logic [SQ_W-1:0]  r_pz2_3;
    lik_pkg::t_sqrt_st r_rs [0:RHO_STEPS];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rho_sq      <= {1'b0, r_px2} + {1'b0, r_py2};
            r_pz2_3       <= r_pz2;
            r_rs[0].rem   <= lik_pkg::SQRT_REM_W'({1'b0, r_px2} + {1'b0, r_py2});
            r_rs[0].root  <= '0;
        end
    end

    // Stage 4: law-of-cosines numerator.
    logic signed [NUM_W-1:0] r_num;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_num <= $signed({{(NUM_W-RSQ_W){1'b0}}, r_rho_sq})
                   + $signed({{(NUM_W-SQ_W){1'b0}}, r_pz2_3})
                   - $signed({{(NUM_W-DEN_W){1'b0}}, r_asum});
        end
    end

    // Stage 5: saturate the cosine or prepare the magnitude for division.
    logic signed [NUM_W-1:0] den_s;
    logic signed [NUM_W-1:0] num_abs;
    logic [REM_W-1:0]        r_div_rem [0:DIV_STEPS];
    logic [Q_W-1:0]          r_div_q   [0:DIV_STEPS];
    lik_pkg::t_cls           r_cls     [0:DIV_STEPS];

    assign den_s   = $signed({{(NUM_W-DEN_W){1'b0}}, r_den});
    assign num_abs = r_num[NUM_W-1] ? -r_num : r_num;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cls[0].sat_hi <= r_den_zero || (r_num > den_s);
            r_cls[0].sat_lo <= !r_den_zero && (r_num < -den_s);
            r_cls[0].neg    <= r_num[NUM_W-1];
            r_div_rem[0]    <= {1'b0, num_abs[DEN_W-1:0]};
            r_div_q[0]      <= '0;
        end
    end

    // Restoring divider, one quotient bit per stage, most significant bit first.
    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        logic [REM_W-1:0] sh;
        logic             ge;
        assign sh = (j == 0) ? r_div_rem[j] : (r_div_rem[j] << 1);
        assign ge = (sh >= {1'b0, r_den});
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_div_rem[j+1] <= ge ? sh - {1'b0, r_den} : sh;
                r_div_q[j+1]   <= {r_div_q[j][Q_W-2:0], ge};
                r_cls[j+1]     <= r_cls[j];
            end
        end
    end

    // Knee cosine and reach flag.
    logic signed [C2_W-1:0] r_c2;
    logic                   r_reach;
    lik_pkg::t_cls          cls_d;
    logic signed [C2_W-1:0] q_s;

    assign cls_d = r_cls[DIV_STEPS];
    assign q_s   = $signed({1'b0, r_div_q[DIV_STEPS]});

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (cls_d.sat_hi) begin
                r_c2 <= ONE;
            end else if (cls_d.sat_lo) begin
                r_c2 <= -ONE;
            end else begin
                r_c2 <= cls_d.neg ? -q_s : q_s;
            end
            r_reach <= !(cls_d.sat_hi || cls_d.sat_lo);
        end
    end

    // Cosine square and lower link times cosine.
    logic signed [2*C2_W-1:0] n_c2sq;
    logic [C2SQ_W-1:0]        r_c2sq;
    logic signed [A2C2_W-1:0] r_a2c2;

    assign n_c2sq = r_c2 * r_c2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c2sq <= n_c2sq[C2SQ_W-1:0];
            r_a2c2 <= $signed({1'b0, r_lower_link}) * r_c2;
        end
    end

    // Sine radicand and the hip's in-line term k.
    logic signed [A2C2_W-1:0] a2c2_sh;
    logic signed [K_W-1:0]    r_k;
    lik_pkg::t_sqrt_st        r_ss [0:S_STEPS];

    assign a2c2_sh = r_a2c2 >>> F;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_k          <= $signed({{(K_W-LEN_W){1'b0}}, r_upper_link}) + a2c2_sh[K_W-1:0];
            r_ss[0].rem  <= lik_pkg::SQRT_REM_W'((C2SQ_W'(1) << (2 * F)) - r_c2sq);
            r_ss[0].root <= '0;
        end
    end

    // Square roots, one result bit per stage.
    for (genvar j = 0; j < S_STEPS; j++) begin : g_ssqrt
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_ss[j+1] <= lik_pkg::sqrt_step(r_ss[j], S_STEPS - 1 - j);
            end
        end
    end

    for (genvar j = 0; j < RHO_STEPS; j++) begin : g_rsqrt
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rs[j+1] <= lik_pkg::sqrt_step(r_rs[j], RHO_STEPS - 1 - j);
            end
        end
    end

    // Knee sine on the negative branch, and lower link times its magnitude.
    logic [SMAG_W-1:0]      smag;
    logic signed [C2_W-1:0] r_s2;
    logic [M_W-1:0]         r_m;

    assign smag = r_ss[S_STEPS].root[SMAG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2 <= -$signed({1'b0, smag});
            r_m  <= r_lower_link * smag;
        end
    end

    // Out-of-line term t = floor(a2 * s2 / 2^F).
    logic signed [M_W:0]  m_neg;
    logic signed [M_W:0]  m_sh;
    logic signed [T_W-1:0] r_t;

    assign m_neg = -$signed({1'b0, r_m});
    assign m_sh  = m_neg >>> F;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t <= m_sh[T_W-1:0];
        end
    end

    // Delay lines that line values up with the stage that uses them.
    logic signed [POS_W-1:0] r_pz_d  [1:PZ_DLY];
    logic signed [K_W-1:0]   r_k_d   [1:K_DLY];
    logic [RHO_W-1:0]        r_rho_d [1:RHO_DLY];
    logic signed [C2_W-1:0]  r_c2_d  [1:C2_DLY];
    logic                    r_reach_d [1:REACH_DLY];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pz_d[1]    <= r_pz;
            r_k_d[1]     <= r_k;
            r_rho_d[1]   <= r_rs[RHO_STEPS].root[RHO_W-1:0];
            r_c2_d[1]    <= r_c2;
            r_reach_d[1] <= r_reach;
            for (int k = 2; k <= PZ_DLY; k++) begin
                r_pz_d[k] <= r_pz_d[k-1];
            end
            for (int k = 2; k <= K_DLY; k++) begin
                r_k_d[k] <= r_k_d[k-1];
            end
            for (int k = 2; k <= RHO_DLY; k++) begin
                r_rho_d[k] <= r_rho_d[k-1];
            end
            for (int k = 2; k <= C2_DLY; k++) begin
                r_c2_d[k] <= r_c2_d[k-1];
            end
            for (int k = 2; k <= REACH_DLY; k++) begin
                r_reach_d[k] <= r_reach_d[k-1];
            end
        end
    end

    // Hip rotation products.
    logic signed [RHO_W:0]             rho_s;
    logic signed [K_W+POS_W-1:0]       n_kpz;
    logic signed [T_W+RHO_W:0]         n_trho;
    logic signed [K_W+RHO_W:0]         n_krho;
    logic signed [T_W+POS_W-1:0]       n_tpz;
    logic signed [K_W+POS_W-1:0]       r_kpz;
    logic signed [T_W+RHO_W:0]         r_trho;
    logic signed [K_W+RHO_W:0]         r_krho;
    logic signed [T_W+POS_W-1:0]       r_tpz;

    assign rho_s  = $signed({1'b0, r_rho_d[RHO_DLY]});
    assign n_kpz  = r_k_d[K_DLY] * r_pz_d[PZ_DLY];
    assign n_trho = r_t * rho_s;
    assign n_krho = r_k_d[K_DLY] * rho_s;
    assign n_tpz  = r_t * r_pz_d[PZ_DLY];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_kpz  <= n_kpz;
            r_trho <= n_trho;
            r_krho <= n_krho;
            r_tpz  <= n_tpz;
        end
    end

    // Hip atan2 arguments.
    logic signed [PROD_W-1:0] r_s1;
    logic signed [PROD_W-1:0] r_c1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1 <= -PROD_W'(r_kpz) - PROD_W'(r_trho);
            r_c1 <= PROD_W'(r_krho) - PROD_W'(r_tpz);
        end
    end

    // Three atan2 units.
    logic signed [lik_pkg::ANGLE_W-1:0] hip_a;
    logic signed [lik_pkg::ANGLE_W-1:0] knee_a;
    logic signed [lik_pkg::ANGLE_W-1:0] abd_a;

    lik_cordic #(
        .DATA_W     (PROD_W),
        .ITERATIONS (ANGLE_ITERATIONS)
    ) u_hip_cordic (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (r_s1),
        .i_x     (r_c1),
        .o_angle (hip_a)
    );

    lik_cordic #(
        .DATA_W     (C2_W),
        .ITERATIONS (ANGLE_ITERATIONS)
    ) u_knee_cordic (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (r_s2),
        .i_x     (r_c2_d[C2_DLY]),
        .o_angle (knee_a)
    );

    lik_cordic #(
        .DATA_W     (POS_W),
        .ITERATIONS (ANGLE_ITERATIONS)
    ) u_abd_cordic (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (r_py),
        .i_x     (r_px),
        .o_angle (abd_a)
    );

    // Align the early angles with the hip result.
    logic signed [lik_pkg::ANGLE_W-1:0] r_knee_d [1:KNEE_DLY];
    logic signed [lik_pkg::ANGLE_W-1:0] r_abd_d  [1:ABD_DLY];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_knee_d[1] <= knee_a;
            r_abd_d[1]  <= abd_a;
            for (int k = 2; k <= KNEE_DLY; k++) begin
                r_knee_d[k] <= r_knee_d[k-1];
            end
            for (int k = 2; k <= ABD_DLY; k++) begin
                r_abd_d[k] <= r_abd_d[k-1];
            end
        end
    end

    // Output transaction.
    assign o_joint.valid           = r_vld[T_LAST];
    assign o_joint.abduction_angle = r_abd_d[ABD_DLY];
    assign o_joint.hip_angle       = hip_a;
    assign o_joint.knee_angle      = r_knee_d[KNEE_DLY];
    assign o_joint.reachable       = r_reach_d[REACH_DLY];

endmodule
